// File: rtl/bitmap_contiguous_block_allocator_macros.svh
// Assertion helpers for the block allocator.
`ifndef BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcba: assertion failed");

// next-cycle implication, checked outside reset
`define BCBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcba: assertion failed");

`endif

// File: rtl/bcba_pkg.sv
package bcba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int SEG_W     = BIT_W + 1;

  localparam int PTR_W   = 17;
  localparam int BLK_W   = 16;
  localparam int LEN_W   = 17;
  localparam int DELTA_W = 18;
  localparam int REQ_W   = 3;
  localparam int DS_W    = 16;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam int DEFAULT_MAX_BLOCKS = 65536;
  localparam logic [PTR_W-1:0] TOTAL_RESET = 17'h10000;

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_START = 1'b1;

  localparam logic [REQ_W-1:0] REQ_MARK_USED = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MARK_FREE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ADJUST    = 3'd4;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic             found;
    logic             hit;
    logic [SEG_W-1:0] len;
  } seg_t;

endpackage

// File: rtl/bcba_seg.sv
module bcba_seg (
  input  logic [bcba_pkg::WORD_BITS-1:0] word,
  input  bcba_pkg::ptr_t                 p,
  input  bcba_pkg::ptr_t                 size,
  input  bcba_pkg::ptr_t                 rem,
  input  bcba_pkg::ptr_t                 run,
  input  bcba_pkg::ptr_t                 want,
  output bcba_pkg::seg_t                 res
);
  import bcba_pkg::*;

  logic [BIT_W-1:0]     off;
  logic [SEG_W-1:0]     room;
  logic [SEG_W-1:0]     lim;
  logic [SEG_W-1:0]     f;
  ptr_t                 sp;
  ptr_t                 need;
  logic [WORD_BITS-1:0] u;
  logic [PTR_W:0]       reach;

  // one segment: free stretch from p up to the next used bit, word end,
  // volume end, scan budget or end of the wanted run, whichever comes first
  always_comb begin
    off  = p[BIT_W-1:0];
    room = SEG_W'(WORD_BITS) - {1'b0, off};
    sp   = size - p;
    lim  = room;
    if (sp < PTR_W'(lim)) lim = sp[SEG_W-1:0];
    if (rem < PTR_W'(lim)) lim = rem[SEG_W-1:0];
    u = (word >> off) & ~({WORD_BITS{1'b1}} << lim);
    f = lim;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (u[i]) f = SEG_W'(i);
    end
    reach     = {1'b0, run} + (PTR_W+1)'(f);
    need      = want - run;
    res.found = (reach >= {1'b0, want});
    res.hit   = !res.found && (u != '0);
    if (res.found) begin
      res.len = need[SEG_W-1:0];
    end else if (res.hit) begin
      res.len = f + SEG_W'(1);
    end else begin
      res.len = lim;
    end
  end

endmodule

// File: rtl/bitmap_contiguous_block_allocator.sv
// Next-fit contiguous block allocator over a usage bitmap held in a
// memory of 32-bit words with one write and one read port (one bit per
// block, 1 = used). After reset the bitmap is swept clear, one word per
// cycle, and in_stall stays high; register writes are taken meanwhile.
// Requests run one at a time: mark, status and adjust pass through the
// execute and result states before out_valid rises, and the next request
// is accepted once the block is back in the idle state.
// Allocate adds one scan step per segment, where a segment ends at a
// used block, a 32-bit word boundary, the volume end or the scan limit;
// the scan wraps from the volume end back to data_start and covers at
// most total_blocks blocks. Each segment lies within one bitmap word,
// and the memory read port returns one word per cycle.
// The next request is accepted as soon as the result moves into the
// output register, even while that result is still stalled.
`include "bitmap_contiguous_block_allocator_macros.svh"

module bitmap_contiguous_block_allocator #(
  parameter int MAX_BLOCKS = bcba_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcba_pkg::CFG_AW-1:0]     paddr,
  input  logic [bcba_pkg::CFG_DW-1:0]     pwdata,
  output logic [bcba_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bcba_pkg::REQ_W-1:0]      req_type,
  input  logic [bcba_pkg::BLK_W-1:0]      block_index,
  input  logic [bcba_pkg::LEN_W-1:0]      run_length,
  input  logic signed [bcba_pkg::DELTA_W-1:0] pointer_delta,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            block_used,
  output logic [bcba_pkg::BLK_W-1:0]      alloc_start,
  output logic                            alloc_failed,
  output logic [bcba_pkg::PTR_W-1:0]      search_pointer
);
  import bcba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAX_CAP   = (MAX_BLOCKS > 131071) ? 131071 : MAX_BLOCKS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t state, state_next;

  ptr_t                     total_blocks;
  logic [DS_W-1:0]          data_start;
  ptr_t                     next_search, next_search_next;

  logic [REQ_W-1:0]         req;
  logic [BLK_W-1:0]         blk;
  ptr_t                     want;
  logic signed [DELTA_W-1:0] delta;

  ptr_t                     p, p_next;
  ptr_t                     run, run_next;
  ptr_t                     rem, rem_next;
  logic                     res_used, res_used_next;
  logic [BLK_W-1:0]         res_start, res_start_next;
  logic                     res_failed, res_failed_next;
  logic [AW-1:0]            clr_idx, clr_idx_next;

  logic [WORD_BITS-1:0]     mem [MAP_WORDS];
  logic [WORD_BITS-1:0]     mem_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic [WORD_BITS-1:0]     mem_wdata;

  ptr_t                     size;
  ptr_t                     ds_ext;
  ptr_t                     p_max;
  ptr_t                     p_start;
  ptr_t                     p_adv;
  ptr_t                     rem_left;
  logic                     blk_in;
  logic                     is_mark;
  logic [WORD_BITS-1:0]     blk_bit;
  logic signed [DELTA_W:0]  adj;
  logic                     wr_cfg;
  logic                     out_free;
  seg_t                     sg;

  bcba_seg u_seg (
    .word (mem_q),
    .p    (p),
    .size (size),
    .rem  (rem),
    .run  (run),
    .want (want),
    .res  (sg)
  );

  // configuration registers
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == REG_START) begin
      prdata = CFG_DW'(data_start);
    end else begin
      prdata = CFG_DW'(total_blocks);
    end
  end

  assign size    = (total_blocks > PTR_W'(MAX_CAP)) ? PTR_W'(MAX_CAP) : total_blocks;
  assign ds_ext  = PTR_W'(data_start);
  assign p_max   = (next_search < ds_ext) ? ds_ext : next_search;
  assign p_start = (p_max >= size) ? ds_ext : p_max;
  assign blk_in  = (PTR_W'(blk) < size);
  assign is_mark = (req == REQ_MARK_USED) || (req == REQ_MARK_FREE);
  assign blk_bit = WORD_BITS'(1) << blk[BIT_W-1:0];
  assign adj     = $signed({2'b00, next_search}) + (DELTA_W+1)'(delta);
  assign p_adv   = p + PTR_W'(sg.len);
  assign rem_left = rem - PTR_W'(sg.len);
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next       = state;
    next_search_next = next_search;
    p_next           = p;
    run_next         = run;
    rem_next         = rem;
    res_used_next    = res_used;
    res_start_next   = res_start;
    res_failed_next  = res_failed;
    clr_idx_next     = clr_idx;
    case (state)
      ST_CLEAR: begin
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == AW'(MAP_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        res_used_next   = 1'b0;
        res_start_next  = '0;
        res_failed_next = 1'b0;
        state_next      = ST_RESULT;
        case (req)
          REQ_STATUS: begin
            res_used_next = !blk_in || mem_q[blk[BIT_W-1:0]];
          end
          REQ_ALLOC: begin
            if (want == '0) begin
              res_failed_next = 1'b1;
            end else if (size == '0) begin
              res_failed_next  = 1'b1;
              next_search_next = p_max;
            end else if (ds_ext >= size) begin
              // every visit lands past the volume end
              res_failed_next  = 1'b1;
              next_search_next = ds_ext + PTR_W'(1);
            end else begin
              p_next     = p_start;
              run_next   = '0;
              rem_next   = size;
              state_next = ST_SCAN;
            end
          end
          REQ_ADJUST: begin
            if (adj < $signed({3'b000, data_start}) || adj >= $signed({2'b00, size})) begin
              next_search_next = ds_ext;
            end else begin
              next_search_next = adj[PTR_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        rem_next = rem_left;
        if (sg.found) begin
          res_start_next   = p_adv[BLK_W-1:0] - want[BLK_W-1:0];
          next_search_next = p_adv;
          state_next       = ST_RESULT;
        end else if (rem_left == '0) begin
          res_failed_next  = 1'b1;
          next_search_next = p_adv;
          state_next       = ST_RESULT;
        end else if (p_adv >= size) begin
          p_next   = ds_ext;
          run_next = '0;
        end else begin
          p_next   = p_adv;
          run_next = sg.hit ? '0 : run + PTR_W'(sg.len);
        end
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // bitmap port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(blk[BLK_W-1:BIT_W]);
    mem_wdata = mem_q;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (state == ST_EXEC && is_mark && blk_in) begin
      mem_we = 1'b1;
      if (req == REQ_MARK_USED) begin
        mem_wdata = mem_q | blk_bit;
      end else begin
        mem_wdata = mem_q & ~blk_bit;
      end
    end
    if (state == ST_IDLE) begin
      mem_raddr = AW'(block_index[BLK_W-1:BIT_W]);
    end else if (state == ST_SCAN || (state == ST_EXEC && req == REQ_ALLOC)) begin
      mem_raddr = AW'(p_next[PTR_W-1:BIT_W]);
    end else begin
      mem_raddr = AW'(blk[BLK_W-1:BIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      total_blocks <= TOTAL_RESET;
      data_start   <= '0;
      next_search  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      next_search <= next_search_next;
      if (wr_cfg) begin
        if (paddr[2] == REG_START) begin
          data_start <= pwdata[DS_W-1:0];
        end else begin
          total_blocks <= pwdata[PTR_W-1:0];
        end
      end
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (state == ST_IDLE && in_valid) begin
      req   <= req_type;
      blk   <= block_index;
      want  <= run_length;
      delta <= pointer_delta;
    end
    p          <= p_next;
    run        <= run_next;
    rem        <= rem_next;
    res_used   <= res_used_next;
    res_start  <= res_start_next;
    res_failed <= res_failed_next;
    if (state == ST_RESULT && out_free) begin
      block_used     <= res_used;
      alloc_start    <= res_start;
      alloc_failed   <= res_failed;
      search_pointer <= next_search;
    end
  end

  `BCBA_ASSERT_NOW(a_scan_window, state == ST_SCAN, rem != '0 && p < size)
  `BCBA_ASSERT_NOW(a_scan_run, state == ST_SCAN, run < want)
  `BCBA_ASSERT_NEXT(a_result_load, state == ST_RESULT && out_free, out_valid)

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcba_pkg::*;

  localparam int    CLK_PERIOD   = 4;
  localparam longint TIMEOUT_NS  = 40_000_000;
  localparam int    DRAIN_CYCLES = 8;
  localparam int    TAIL_CYCLES  = 16;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    PHASE_ITEMS  = 41;
  localparam int    NUM_PHASES   = 6;

  localparam logic [REQ_W-1:0]  REQ_RESERVED_LO = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_RESERVED_HI = 3'd7;
  localparam logic [CFG_AW-1:0] ADDR_TOTAL = {REG_TOTAL, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_START = {REG_START, 2'b00};
  localparam int TOTAL_MASK = 'h1FFFF;
  localparam int START_MASK = 'hFFFF;

  typedef struct packed {
    logic             used;
    logic [BLK_W-1:0] start;
    logic             failed;
    ptr_t             ptr;
  } req_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_AW-1:0]         paddr = '0;
  logic [CFG_DW-1:0]         pwdata = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          req_type = '0;
  logic [BLK_W-1:0]          block_index = '0;
  logic [LEN_W-1:0]          run_length = '0;
  logic signed [DELTA_W-1:0] pointer_delta = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      block_used;
  logic [BLK_W-1:0]          alloc_start;
  logic                      alloc_failed;
  logic [PTR_W-1:0]          search_pointer;

  bit          used_map [0:DEFAULT_MAX_BLOCKS-1];
  int          model_next = 0;
  int          cfg_total = DEFAULT_MAX_BLOCKS;
  int          cfg_start = 0;
  req_result_t pending_results[$];
  req_result_t got_res;
  req_result_t exp_res;
  req_result_t last_res;
  int          claimed_blocks[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit holding = 1'b0;
  event hold_ev;

  int errors = 0;
  int n_sent = 0;
  int n_alloc = 0;
  int n_alloc_fail = 0;
  int n_checked = 0;

  int phase_total [NUM_PHASES] = '{65536, 1000, 64, 131071, 300, 2048};
  int phase_start [NUM_PHASES] = '{0, 100, 0, 65000, 290, 0};

  bitmap_contiguous_block_allocator u_top (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int volume();
    return (cfg_total > DEFAULT_MAX_BLOCKS) ? DEFAULT_MAX_BLOCKS : cfg_total;
  endfunction

  function automatic req_result_t predict_request(
    input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk,
    input logic [LEN_W-1:0] want, input logic signed [DELTA_W-1:0] delta);
    req_result_t r;
    int vol;
    int p;
    int run;
    int it;
    bit found;
    longint s;
    r = '0;
    vol = volume();
    case (req)
      REQ_MARK_USED: if (blk < vol) used_map[blk] = 1'b1;
      REQ_MARK_FREE: if (blk < vol) used_map[blk] = 1'b0;
      REQ_STATUS:    r.used = (blk >= vol) ? 1'b1 : used_map[blk];
      REQ_ALLOC: begin
        n_alloc++;
        if (want == 0) begin
          r.failed = 1'b1;
        end else begin
          p = (model_next < cfg_start) ? cfg_start : model_next;
          run = 0;
          it = 0;
          found = 1'b0;
          while (it < vol && !found) begin
            if (p >= vol) begin
              p = cfg_start;
              run = 0;
            end
            if (p >= vol || used_map[p]) run = 0;
            else run++;
            p++;
            if (run >= want) found = 1'b1;
            it++;
          end
          if (found) r.start = BLK_W'(p - run);
          r.failed = !found;
          model_next = p & TOTAL_MASK;
        end
        if (r.failed) n_alloc_fail++;
      end
      REQ_ADJUST: begin
        s = longint'(model_next) + longint'(delta);
        if (s < longint'(cfg_start) || s >= longint'(vol)) s = cfg_start;
        model_next = int'(s) & TOTAL_MASK;
      end
      default: ;
    endcase
    r.ptr = ptr_t'(model_next);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // one request transaction; called and returns at a falling edge
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk,
                          input logic [LEN_W-1:0] want,
                          input logic signed [DELTA_W-1:0] delta,
                          output req_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    block_index   <= blk;
    run_length    <= want;
    pointer_delta <= delta;
    do @(posedge clk); while (in_stall);
    res = predict_request(req, blk, want, delta);
    pending_results.push_back(res);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic set_volume(input int total, input int start);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b1, ADDR_TOTAL, CFG_DW'(total), rd);
    apb_xfer(1'b0, ADDR_TOTAL, '0, rd);
    check_field("total_blocks readback", total & TOTAL_MASK, rd);
    apb_xfer(1'b1, ADDR_START, CFG_DW'(start), rd);
    apb_xfer(1'b0, ADDR_START, '0, rd);
    check_field("data_start readback", start & START_MASK, rd);
    cfg_total = total & TOTAL_MASK;
    cfg_start = start & START_MASK;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed();
    send_req(REQ_STATUS,    16'd0,     '0,        '0,          last_res);
    send_req(REQ_MARK_USED, 16'd0,     '0,        '0,          last_res);
    send_req(REQ_MARK_USED, 16'hFFFF,  '0,        '0,          last_res);
    send_req(REQ_STATUS,    16'hFFFF,  '0,        '0,          last_res);
    send_req(REQ_STATUS,    16'd0,     '0,        '0,          last_res);
    send_req(REQ_ALLOC,     16'd0,     17'd0,     '0,          last_res);
    send_req(REQ_ALLOC,     16'd0,     17'd1,     '0,          last_res);
    send_req(REQ_ALLOC,     16'd0,     17'h10000, '0,          last_res);
    send_req(REQ_ADJUST,    16'd0,     '0,        18'sh1FFFF,  last_res);
    send_req(REQ_ADJUST,    16'd0,     '0,        18'sh20000,  last_res);
    send_req(REQ_ADJUST,    16'd0,     '0,        18'sd5,      last_res);
    send_req(REQ_RESERVED_LO, 16'hFFFF, 17'h1FFFF, 18'sh3FFFF, last_res);
    send_req(REQ_RESERVED_HI, 16'd7,   17'd3,     18'sd9,      last_res);
    send_req(REQ_MARK_FREE, 16'd0,     '0,        '0,          last_res);
    send_req(REQ_STATUS,    16'd0,     '0,        '0,          last_res);
  endtask

  task automatic test_config_corners();
    drain();
    set_volume(0, 0);
    send_req(REQ_STATUS,    16'd5,     '0,    '0,     last_res);
    send_req(REQ_MARK_USED, 16'd3,     '0,    '0,     last_res);
    send_req(REQ_ALLOC,     16'd0,     17'd1, '0,     last_res);
    drain();
    set_volume(TOTAL_MASK, 0);
    send_req(REQ_STATUS,    16'hFFFF,  '0,    '0,     last_res);
    drain();
    set_volume(100, 200);
    send_req(REQ_ALLOC,     16'd0,     17'd1, '0,     last_res);
    send_req(REQ_ADJUST,    16'd0,     '0,    18'sd1, last_res);
    drain();
    set_volume(1, 0);
    send_req(REQ_ALLOC,     16'd0,     17'd1, '0,     last_res);
    send_req(REQ_ALLOC,     16'd0,     17'd1, '0,     last_res);
    drain();
    set_volume(DEFAULT_MAX_BLOCKS, START_MASK);
    send_req(REQ_ALLOC,     16'd0,     17'd1, '0,     last_res);
  endtask

  task automatic test_backpressure();
    drain();
    set_volume(256, 16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_ev;
    repeat (20) begin
      send_req($urandom_range(1) ? REQ_STATUS : REQ_ADJUST, 16'($urandom_range(300)), '0,
               18'(int'($urandom_range(64)) - 32), last_res);
    end
  endtask

  task automatic test_random();
    int count;
    int pick;
    int vol;
    int k;
    int idx;
    logic [LEN_W-1:0] want;
    logic [BLK_W-1:0] blk;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      set_volume(phase_total[ph], phase_start[ph]);
      send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 77 : 0;
      recv_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 12 : 0;
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        vol  = volume();
        blk  = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(vol - 1));
        if (pick < 35) begin
          // allocate a run, then claim its blocks
          k = $urandom_range(9);
          want = (k == 0) ? 17'($urandom()) : (k == 1) ? 17'($urandom_range(vol)) :
                 17'($urandom_range(8, 1));
          send_req(REQ_ALLOC, 16'($urandom()), want, 18'($urandom()), last_res);
          count++;
          if (!last_res.failed && want <= 8) begin
            for (k = 0; k < int'(want) && count < PHASE_ITEMS; k++) begin
              send_req(REQ_MARK_USED, last_res.start + BLK_W'(k), 17'($urandom()),
                       18'($urandom()), got_res);
              claimed_blocks.push_back(int'(last_res.start) + k);
              count++;
            end
          end
        end else if (pick < 52) begin
          if (claimed_blocks.size() != 0 && $urandom_range(3) != 0) begin
            idx = $urandom_range(claimed_blocks.size() - 1);
            blk = BLK_W'(claimed_blocks[idx]);
            claimed_blocks.delete(idx);
          end
          send_req(REQ_MARK_FREE, blk, 17'($urandom()), 18'($urandom()), last_res);
          count++;
        end else if (pick < 68) begin
          send_req(REQ_STATUS, blk, 17'($urandom()), 18'($urandom()), last_res);
          count++;
        end else if (pick < 80) begin
          send_req(REQ_MARK_USED, blk, 17'($urandom()), 18'($urandom()), last_res);
          count++;
        end else if (pick < 94) begin
          send_req(REQ_ADJUST, 16'($urandom()), 17'($urandom()),
                   ($urandom_range(3) == 0) ? 18'($urandom()) :
                   18'(int'($urandom_range(2 * vol)) - vol), last_res);
          count++;
        end else begin
          send_req(3'($urandom_range(REQ_RESERVED_HI, REQ_RESERVED_LO)), 16'($urandom()),
                   17'($urandom()), 18'($urandom()), last_res);
          count++;
        end
      end
    end
    drain();
  endtask

  always @(negedge clk) begin
    out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      @(negedge clk);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      holding = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, got ptr %0h", $time,
                 search_pointer);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("block_used",     exp_res.used,   block_used);
        check_field("alloc_start",    exp_res.start,  alloc_start);
        check_field("alloc_failed",   exp_res.failed, alloc_failed);
        check_field("search_pointer", exp_res.ptr,    search_pointer);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_config_corners();
    test_backpressure();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Sent %0d requests incl. %0d allocates (%0d predicted to fail) over %0d volumes",
             n_sent, n_alloc, n_alloc_fail, NUM_PHASES + 7);
    $display("Checked %0d results with stalls on both sides, %0d mismatches", n_checked,
             errors);
    if (errors == 0) begin
      $display("** bitmap_contiguous_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_contiguous_block_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("** bitmap_contiguous_block_allocator: FAILED **");
    $finish;
  end

endmodule
